// ===== sv/utu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utu_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package utu_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CP_W         = 21;
  localparam int unsigned CODE_W       = 16;
  localparam int unsigned PAIR_W       = 20;
  localparam int unsigned UNIT_COUNT_W = 10;
  localparam int unsigned ENTRY_W      = 7;
  localparam int unsigned M_TDATA_W    = 40;

  localparam logic [CP_W-1:0]   CP_MAX_1 = 21'h00007F;
  localparam logic [CP_W-1:0]   CP_MAX_2 = 21'h0007FF;
  localparam logic [CP_W-1:0]   CP_MAX_3 = 21'h00FFFF;
  localparam logic [CP_W-1:0]   CP_LIMIT = 21'h10FFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h010000;
  localparam logic [4:0]        SURR_TAG  = 5'b11011;
  localparam logic [CODE_W-1:0] SURR_HIGH = 16'hD800;
  localparam logic [CODE_W-1:0] SURR_LOW  = 16'hDC00;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // Entries are ceil(units / ENTRY_UNITS) but at least one, done as a reciprocal
  // multiply. The reciprocal is exact for dividends below 2**17.
  localparam int unsigned ENTRY_UNITS   = 13;
  localparam int unsigned ENTRY_SHIFT   = 20;
  localparam int unsigned ENTRY_RECIP_W = 17;
  localparam logic [ENTRY_RECIP_W-1:0] ENTRY_RECIP =
    ENTRY_RECIP_W'(((1 << ENTRY_SHIFT) + ENTRY_UNITS - 1) / ENTRY_UNITS);

  typedef enum logic [1:0] {
    CMD_UNIT = 2'd0,
    CMD_PAIR = 2'd1,
    CMD_TERM = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [PAIR_W-1:0] value;
    logic              trunc;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/utu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utu_front
// Byte decoder: collects UTF-8 sequences, validates each code point and
// issues unit, pair and terminator commands.
// ----------------------------------------------------------------------------
module utu_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  input  wire  [utu_pkg::BYTE_W-1:0] s_tdata,
  input  wire                        q_full,
  output logic                       push,
  output utu_pkg::cmd_t              push_cmd
);
  import utu_pkg::*;

  logic [CP_W-1:0] acc, acc_next;
  logic [1:0]      rem, rem_next;
  logic [2:0]      len, len_next;
  logic            stopped, stopped_next;

  logic            accept;
  logic [CP_W-1:0] cp_cont;
  logic [2:0]      need;
  logic            bad_cp;
  logic [CP_W-1:0] cp_off;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;

  assign cp_cont = {acc[CP_W-7:0], s_tdata[5:0]};
  assign cp_off  = cp_cont - SUPP_BASE;

  always_comb begin
    if (cp_cont <= CP_MAX_1) begin
      need = 3'd1;
    end else if (cp_cont <= CP_MAX_2) begin
      need = 3'd2;
    end else if (cp_cont <= CP_MAX_3) begin
      need = 3'd3;
    end else begin
      need = 3'd4;
    end
    bad_cp = (need != len) || (cp_cont > CP_LIMIT) ||
             ((cp_cont[CP_W-1:CODE_W] == '0) && (cp_cont[15:11] == SURR_TAG));
  end

  always_comb begin
    acc_next     = acc;
    rem_next     = rem;
    len_next     = len;
    stopped_next = stopped;
    push         = 1'b0;
    push_cmd     = '{kind: CMD_UNIT, value: '0, trunc: 1'b0};
    if (accept) begin
      if (s_tdata == '0) begin
        push           = 1'b1;
        push_cmd.kind  = CMD_TERM;
        push_cmd.trunc = stopped || (rem != 2'd0);
        acc_next       = '0;
        rem_next       = 2'd0;
        len_next       = 3'd0;
        stopped_next   = 1'b0;
      end else if (stopped) begin
        stopped_next = 1'b1;
      end else if (rem != 2'd0) begin
        if (s_tdata[7:6] != 2'b10) begin
          stopped_next = 1'b1;
          rem_next     = 2'd0;
          len_next     = 3'd0;
          acc_next     = '0;
        end else if (rem != 2'd1) begin
          acc_next = cp_cont;
          rem_next = rem - 2'd1;
        end else begin
          acc_next = '0;
          rem_next = 2'd0;
          len_next = 3'd0;
          if (bad_cp) begin
            stopped_next = 1'b1;
          end else if (cp_cont <= CP_MAX_3) begin
            push           = 1'b1;
            push_cmd.kind  = CMD_UNIT;
            push_cmd.value = PAIR_W'(cp_cont);
          end else begin
            push           = 1'b1;
            push_cmd.kind  = CMD_PAIR;
            push_cmd.value = cp_off[PAIR_W-1:0];
          end
        end
      end else if (s_tdata[7] == 1'b0) begin
        push           = 1'b1;
        push_cmd.kind  = CMD_UNIT;
        push_cmd.value = PAIR_W'(s_tdata);
      end else if (s_tdata[7:5] == 3'b110) begin
        acc_next = CP_W'(s_tdata[4:0]);
        len_next = 3'd2;
        rem_next = 2'd1;
      end else if (s_tdata[7:4] == 4'b1110) begin
        acc_next = CP_W'(s_tdata[3:0]);
        len_next = 3'd3;
        rem_next = 2'd2;
      end else if (s_tdata[7:3] == 5'b11110) begin
        acc_next = CP_W'(s_tdata[2:0]);
        len_next = 3'd4;
        rem_next = 2'd3;
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      rem     <= 2'd0;
      len     <= 3'd0;
      stopped <= 1'b0;
    end else begin
      acc     <= acc_next;
      rem     <= rem_next;
      len     <= len_next;
      stopped <= stopped_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/utu_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utu_queue
// Four-entry command queue between the decoder and the unit emitter.
// ----------------------------------------------------------------------------
module utu_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  utu_pkg::cmd_t  push_cmd,
  output logic           full,
  input  wire            pop,
  output utu_pkg::cmd_t  head,
  output logic           empty
);
  import utu_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full  = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/utu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utu_back
// Unit emitter: expands commands into UTF-16 units, keeps the saturating
// unit count and builds the terminator with its counts.
// ----------------------------------------------------------------------------
module utu_back #(
  parameter int MAX_UNITS = 1023
) (
  input  wire                           clk,
  input  wire                           rst,
  input  utu_pkg::cmd_t                 head,
  input  wire                           empty,
  output logic                          pop,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [utu_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import utu_pkg::*;

  localparam int CW = $clog2(MAX_UNITS + 1);
  localparam int XW = CW + 1;
  localparam int PW = XW + ENTRY_RECIP_W;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_inc;
  logic              pend;
  logic [CODE_W-1:0] low_unit;
  logic              load;

  logic [XW-1:0]     ent_x;
  logic [PW-1:0]     ent_prod;
  logic [ENTRY_W-1:0] ent_q;

  logic [CODE_W-1:0]       code_unit;
  logic [UNIT_COUNT_W-1:0] unit_count;
  logic [ENTRY_W-1:0]      entry_count;
  logic                    was_truncated;

  assign load = !m_tvalid || m_tready;
  assign pop  = load && !pend && !empty;

  assign count_inc = (count == CW'(MAX_UNITS)) ? count : count + 1'b1;

  assign ent_x    = XW'(count) + XW'(ENTRY_UNITS - 1);
  assign ent_prod = PW'(ent_x) * PW'(ENTRY_RECIP);
  assign ent_q    = (count == '0) ? ENTRY_W'(1) : ENTRY_W'(ent_prod >> ENTRY_SHIFT);

  assign m_tdata = {6'd0, was_truncated, entry_count, unit_count, code_unit};

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit     <= '0;
      unit_count    <= '0;
      entry_count   <= '0;
      was_truncated <= 1'b0;
      m_tlast       <= 1'b0;
      if (pend) begin
        code_unit <= low_unit;
      end else if (!empty) begin
        case (head.kind)
          CMD_UNIT: begin
            code_unit <= head.value[CODE_W-1:0];
          end
          CMD_PAIR: begin
            code_unit <= SURR_HIGH | CODE_W'(head.value[PAIR_W-1:10]);
            low_unit  <= SURR_LOW | CODE_W'(head.value[9:0]);
          end
          CMD_TERM: begin
            m_tlast       <= 1'b1;
            unit_count    <= UNIT_COUNT_W'(count);
            entry_count   <= ent_q;
            was_truncated <= head.trunc;
          end
          default: begin
            code_unit <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
      count    <= '0;
    end else if (load) begin
      if (pend) begin
        m_tvalid <= 1'b1;
        pend     <= 1'b0;
        count    <= count_inc;
      end else if (!empty) begin
        m_tvalid <= 1'b1;
        case (head.kind)
          CMD_UNIT: begin
            count <= count_inc;
          end
          CMD_PAIR: begin
            pend  <= 1'b1;
            count <= count_inc;
          end
          CMD_TERM: begin
            count <= '0;
          end
          default: begin
            count <= count;
          end
        endcase
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/utf8_to_utf16_transcoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Converts a NUL-terminated UTF-8 name into UTF-16 code units and closes
// each string with a terminator that carries the unit and entry counts.
//
//   Channel   Dir  Payload
//   s_*       in   s_tdata[7:0] data_byte
//   m_*       out  m_tdata code_unit, unit_count, entry_count, was_truncated;
//                  m_tlast is_terminator
//
// One byte is taken per cycle while the command queue is not full.
// A four-byte sequence yields a surrogate pair, sent high unit then low unit by
// the emitter. Reset clears the decoder, the queue and the output stage.
// s_tready falls only when the four-entry command queue is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
  parameter int MAX_UNITS = 1023
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // [7:0] data_byte
  input  wire  [utu_pkg::BYTE_W-1:0]    s_tdata,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // [15:0] code_unit, [25:16] unit_count, [32:26] entry_count,
  // [33] was_truncated, [39:34] zero
  output logic [utu_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import utu_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  utu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  utu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  utu_back #(
    .MAX_UNITS (MAX_UNITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
